@@ src/sarc_pkg.sv @@
package sarc_pkg;

    localparam int WARNINGS = 64;
    localparam int SOUNDS   = 32;

    // Fixed widths of the transaction fields.
    localparam int WARN_IDX_W = 6;
    localparam int SOUND_ID_W = 5;

    // Storage geometry follows from the counts above.
    localparam int WARN_AW = $clog2(WARNINGS);
    localparam int SND_AW  = $clog2(SOUNDS);
    localparam int CNT_W   = $clog2(WARNINGS + 1);

    localparam logic CMD_STOP = 1'b0;
    localparam logic CMD_PLAY = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_RMW
    } sarc_state_t;

    typedef struct packed {
        logic               en;
        logic [WARN_AW-1:0] warn_addr;
        logic [SND_AW-1:0]  snd_addr;
    } sarc_rd_req_t;

    typedef struct packed {
        logic               warn_en;
        logic [WARN_AW-1:0] warn_addr;
        logic               warn_data;
        logic               snd_en;
        logic [SND_AW-1:0]  snd_addr;
        logic [CNT_W-1:0]   snd_data;
    } sarc_wr_req_t;

endpackage

@@ src/shared_alert_sound_refcount_top.sv @@
// Shared alert sound reference counter.
//
// Each input transaction on the s_ channel names a warning source, a shared
// sound and whether that warning wants the sound playing. The block keeps a
// play/stop flag per warning and a user count per sound in two small
// synchronous memories. A stop-to-play change produces a play command on the
// m_ channel; a play-to-stop change produces a stop command only when the
// sound's user count is zero after the update. Other requests produce no transaction.
//
// Each request is handled in a read step, which reads both memories, and
// a write-back step, which modifies, writes back and loads the output
// register; no new request is taken before that. A command is visible on
// the m_ channel the cycle after the write-back. When the receiver stalls,
// the command waits in the output register; the next request is still taken,
// and it only waits in its write-back cycle if it also has a command to send.
// The cfg_ channel writes the suppress_all bit, which turns every request
// into a stop; it is always ready. Reset clears all flags, counts and
// suppress_all at once, with no clearing pass.
module shared_alert_sound_refcount_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [sarc_pkg::WARN_IDX_W-1:0]  s_warning_index,
    input  logic [sarc_pkg::SOUND_ID_W-1:0]  s_sound_id,
    input  logic                             s_play_request,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sarc_pkg::SOUND_ID_W-1:0]  m_sound_out,
    output logic                             m_command,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_suppress_all
);
    import sarc_pkg::*;

    sarc_state_t state_reg, state_next;

    logic                  suppress_reg;
    logic [SND_AW-1:0]     req_snd_reg;
    logic [WARN_AW-1:0]    req_warn_reg;
    logic                  req_play_reg;
    logic                  req_ok_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [SOUND_ID_W-1:0] out_sound_reg;
    logic                  out_cmd_reg;

    sarc_rd_req_t          rd;
    sarc_wr_req_t          wr;
    logic                  rd_warn_playing;
    logic [CNT_W-1:0]      rd_users;

    logic                  in_range;
    logic                  want;
    logic                  rise;
    logic                  fall;
    logic [CNT_W-1:0]      cnt_new;
    logic                  emit;
    logic                  out_free;
    logic                  out_load;
    logic                  commit;

    sarc_store u_store (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .rd              (rd),
        .rd_warn_playing (rd_warn_playing),
        .rd_users        (rd_users),
        .wr              (wr)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);

    // Indexes beyond the configured counts are dropped without a side effect.
    assign in_range = (32'(s_warning_index) < WARNINGS) && (32'(s_sound_id) < SOUNDS);

    always_comb begin
        rd.en        = s_valid && s_ready;
        rd.warn_addr = s_warning_index[WARN_AW-1:0];
        rd.snd_addr  = s_sound_id[SND_AW-1:0];
    end

    // Read-modify-write of the flag and the count.
    assign want = req_play_reg & ~suppress_reg;
    assign rise = ~rd_warn_playing & want;
    assign fall = rd_warn_playing & ~want;

    always_comb begin
        cnt_new = rd_users;
        if (rise && (rd_users < CNT_W'(WARNINGS))) begin
            cnt_new = rd_users + CNT_W'(1);
        end else if (fall && (rd_users != '0)) begin
            cnt_new = rd_users - CNT_W'(1);
        end
    end

    assign emit     = req_ok_reg && (rise || (fall && (cnt_new == '0)));
    assign out_free = !out_valid_reg || m_ready;
    assign commit   = (state_reg == ST_RMW) && (!emit || out_free);
    assign out_load = commit && emit;

    always_comb begin
        wr.warn_en   = commit && req_ok_reg;
        wr.warn_addr = req_warn_reg;
        wr.warn_data = want;
        wr.snd_en    = commit && req_ok_reg && (rise || fall);
        wr.snd_addr  = req_snd_reg;
        wr.snd_data  = cnt_new;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_RMW;
                end
            end
            ST_RMW: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            suppress_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                suppress_reg <= cfg_suppress_all;
            end
        end
    end

    // Request fields are held for the write-back cycle.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_warn_reg <= s_warning_index[WARN_AW-1:0];
            req_snd_reg  <= s_sound_id[SND_AW-1:0];
            req_play_reg <= s_play_request;
            req_ok_reg   <= in_range;
        end
        if (out_load) begin
            out_sound_reg <= SOUND_ID_W'(req_snd_reg);
            out_cmd_reg   <= rise ? CMD_PLAY : CMD_STOP;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_sound_out = out_sound_reg;
    assign m_command   = out_cmd_reg;

    // An accepted request always moves on to its write-back cycle.
    a_accept_to_rmw: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_RMW)
        else $error("accepted request did not enter write-back");

    // Memories are written only in the write-back cycle.
    a_write_in_rmw: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.warn_en || wr.snd_en |-> state_reg == ST_RMW)
        else $error("memory written outside write-back");

    // A play command always leaves the sound with at least one user.
    a_play_count: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && rise |-> wr.snd_en && wr.snd_data != '0)
        else $error("play command with zero users");

    // A stop command is only sent once the count is written back as zero.
    a_stop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && !rise |-> wr.snd_en && wr.snd_data == '0)
        else $error("stop command with remaining users");

    // A waiting command is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !out_load)
        else $error("pending command overwritten");

endmodule

@@ src/sarc_store.sv @@
module sarc_store (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sarc_pkg::sarc_rd_req_t      rd,
    output logic                        rd_warn_playing,
    output logic [sarc_pkg::CNT_W-1:0]  rd_users,
    input  sarc_pkg::sarc_wr_req_t      wr
);
    import sarc_pkg::*;

    logic             warn_mem [WARNINGS];
    logic [CNT_W-1:0] snd_mem  [SOUNDS];

    // One valid bit per entry; an entry never written reads as zero.
    logic [WARNINGS-1:0] warn_vld_reg;
    logic [SOUNDS-1:0]   snd_vld_reg;

    logic             warn_data_reg;
    logic             warn_hit_reg;
    logic [CNT_W-1:0] snd_data_reg;
    logic             snd_hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warn_vld_reg <= '0;
            snd_vld_reg  <= '0;
        end else begin
            if (wr.warn_en) begin
                warn_vld_reg[wr.warn_addr] <= 1'b1;
            end
            if (wr.snd_en) begin
                snd_vld_reg[wr.snd_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.warn_en) begin
            warn_mem[wr.warn_addr] <= wr.warn_data;
        end
        if (wr.snd_en) begin
            snd_mem[wr.snd_addr] <= wr.snd_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            warn_data_reg <= warn_mem[rd.warn_addr];
            warn_hit_reg  <= warn_vld_reg[rd.warn_addr];
            snd_data_reg  <= snd_mem[rd.snd_addr];
            snd_hit_reg   <= snd_vld_reg[rd.snd_addr];
        end
    end

    assign rd_warn_playing = warn_hit_reg & warn_data_reg;
    assign rd_users        = snd_hit_reg ? snd_data_reg : '0;

endmodule

@@ sim/sound_command_tracker_pkg.sv @@
`timescale 1ns / 100ps

package sound_command_tracker_pkg;

    import sarc_pkg::*;

    typedef struct packed {
        logic [SOUND_ID_W-1:0] snd;
        logic                  cmd;
    } sound_cmd_t;

    // Tracks warning flags and per-sound user counts and queues the player
    // commands that the block must produce, in order.
    class sound_command_tracker;

        bit                warn_on [WARNINGS];
        logic [CNT_W-1:0]  users [SOUNDS];
        bit                suppress;
        sound_cmd_t        expected_cmds [$];
        int                errors;

        function new();
            foreach (warn_on[i]) warn_on[i] = 1'b0;
            foreach (users[i]) users[i] = '0;
            suppress = 1'b0;
            errors   = 0;
        endfunction

        function void set_suppress(bit value);
            suppress = value;
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        // Applies one accepted request and queues the command it causes, if any.
        function void note_request(logic [WARN_IDX_W-1:0] w, logic [SOUND_ID_W-1:0] s,
                                   logic play);
            bit         want;
            bit         was;
            sound_cmd_t cmd_item;
            if (int'(w) >= WARNINGS || int'(s) >= SOUNDS) return;
            want       = play && !suppress;
            was        = warn_on[w];
            warn_on[w] = want;
            cmd_item.snd = s;
            if (!was && want) begin
                if (users[s] < WARNINGS) users[s] = users[s] + 1'b1;
                cmd_item.cmd = CMD_PLAY;
                expected_cmds.push_back(cmd_item);
            end else if (was && !want) begin
                if (users[s] != 0) users[s] = users[s] - 1'b1;
                if (users[s] == 0) begin
                    cmd_item.cmd = CMD_STOP;
                    expected_cmds.push_back(cmd_item);
                end
            end
        endfunction

        // Compares one command taken from the block with the oldest expected one.
        function void check_command(logic [SOUND_ID_W-1:0] snd, logic cmd);
            sound_cmd_t want_item;
            if (expected_cmds.size() == 0) begin
                $display("%0t: unexpected command, sound %0d command %0b", $time, snd, cmd);
                errors++;
                return;
            end
            want_item = expected_cmds.pop_front();
            if (snd !== want_item.snd) begin
                $display("%0t: sound_out expected %0d actual %0d", $time, want_item.snd, snd);
                errors++;
            end
            if (cmd !== want_item.cmd) begin
                $display("%0t: command expected %0b actual %0b", $time, want_item.cmd, cmd);
                errors++;
            end
        endfunction

    endclass

endpackage

@@ sim/shared_alert_sound_refcount_top_test.sv @@
`timescale 1ns / 100ps

module shared_alert_sound_refcount_top_test;

    import sarc_pkg::*;
    import sound_command_tracker_pkg::*;

    // Generous bound: every request waiting out a full sender gap, the
    // read-modify-write and a full receiver stall, several times over.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 250;
    localparam int SETTLE_CYCLES = 4;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [WARN_IDX_W-1:0] s_warning_index;
    logic [SOUND_ID_W-1:0] s_sound_id;
    logic                  s_play_request;
    logic                  m_valid;
    logic                  m_ready;
    logic [SOUND_ID_W-1:0] m_sound_out;
    logic                  m_command;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_suppress_all;

    sound_command_tracker tracker = new();

    // When cleared, neither the sender nor the receiver inserts idle cycles.
    bit idle_on;
    int cycles;
    int stall_left;

    // Stimulus memory only: the sound each warning usually names and the
    // last state it asked for, so that most requests form real play/stop pairs.
    logic [SOUND_ID_W-1:0] home_sound [WARNINGS];
    bit                    last_play [WARNINGS];

    shared_alert_sound_refcount_top DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_warning_index  (s_warning_index),
        .s_sound_id       (s_sound_id),
        .s_play_request   (s_play_request),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sound_out      (m_sound_out),
        .m_command        (m_command),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_suppress_all (cfg_suppress_all)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog. A run that hangs on a handshake ends here as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("shared_alert_sound_refcount_top_test NOT OK");
            $finish;
        end
    end

    // All monitoring happens at the rising edge, where every signal still
    // holds its value from before the edge. A result is checked before the
    // request taken at the same edge is noted; the two can never belong
    // together since a command only leaves after its request is written back.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) tracker.check_command(m_sound_out, m_command);
            if (s_valid && s_ready)
                tracker.note_request(s_warning_index, s_sound_id, s_play_request);
            if (cfg_valid && cfg_ready) tracker.set_suppress(cfg_suppress_all);
        end
    end

    // Receiver back-pressure: random stall bursts with long ready stretches
    // in between, and none once idling is switched off.
    always @(posedge aclk) begin
        if (!idle_on) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 17);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Presents one request and returns at the edge where it is accepted.
    // Valid is only lowered when a sender gap follows, so it never gets two
    // assignments in the same time step.
    task automatic send_request(input logic [WARN_IDX_W-1:0] w,
                                input logic [SOUND_ID_W-1:0] s, input logic play);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_warning_index <= w;
        s_sound_id      <= s;
        s_play_request  <= play;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stops the sender and waits until every expected command has come out,
    // then lets the block settle so that it can finish a silent request.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // The suppress register is only written while the block is idle.
    task automatic write_suppress(input logic value);
        drain();
        cfg_valid        <= 1'b1;
        cfg_suppress_all <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        repeat (2) @(posedge aclk);
    endtask

    // Repeatedly starts a warning on one sound and stops it on another. The
    // stop clears the flag, not the first sound's count, so that count climbs
    // until it saturates at the number of warnings; play is still sent then.
    task automatic pump_sound(input logic [WARN_IDX_W-1:0] w,
                              input logic [SOUND_ID_W-1:0] s,
                              input logic [SOUND_ID_W-1:0] s_other, input int pairs);
        repeat (pairs) begin
            send_request(w, s, 1'b1);
            send_request(w, s_other, 1'b0);
        end
    endtask

    // Mostly well-formed traffic: warnings from a small pool toggle on the
    // sound they usually name, so counts build up and drain again. The rest
    // moves a warning to another sound, or is plain noise over all fields.
    task automatic random_request();
        int                    choice;
        logic [WARN_IDX_W-1:0] w;
        logic [SOUND_ID_W-1:0] s;
        logic                  play;
        choice = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) w = WARN_IDX_W'($urandom_range(0, WARNINGS - 1));
        else w = WARN_IDX_W'($urandom_range(0, 11));
        if (choice < 6) begin
            s    = home_sound[w];
            play = ($urandom_range(0, 9) < 7) ? !last_play[w] : last_play[w];
        end else if (choice < 8) begin
            s             = SOUND_ID_W'($urandom_range(0, SOUNDS - 1));
            home_sound[w] = s;
            play          = 1'($urandom_range(0, 1));
        end else begin
            w    = WARN_IDX_W'($urandom_range(0, WARNINGS - 1));
            s    = SOUND_ID_W'($urandom_range(0, SOUNDS - 1));
            play = 1'($urandom_range(0, 1));
        end
        last_play[w] = play;
        send_request(w, s, play);
    endtask

    initial begin
        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_warning_index  <= '0;
        s_sound_id       <= '0;
        s_play_request   <= 1'b0;
        m_ready          <= 1'b0;
        cfg_valid        <= 1'b0;
        cfg_suppress_all <= 1'b0;
        cycles           <= 0;
        stall_left       <= 0;
        idle_on          = 1'b1;
        foreach (home_sound[i]) home_sound[i] = SOUND_ID_W'($urandom_range(0, 7));
        foreach (last_play[i]) last_play[i] = 1'b0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_suppress(1'b0);

        // Directed part. Extremes of both indexes, repeated play and repeated
        // stop, shared sounds, and the stop that only comes with the last user.
        send_request(6'd0, 5'd0, 1'b1);
        send_request(6'd63, 5'd31, 1'b1);
        send_request(6'd0, 5'd0, 1'b1);
        send_request(6'd5, 5'd0, 1'b0);
        send_request(6'd62, 5'd31, 1'b1);
        send_request(6'd63, 5'd31, 1'b0);
        send_request(6'd62, 5'd31, 1'b0);
        send_request(6'd0, 5'd0, 1'b0);
        // A stop naming a sound nobody uses: the count stays empty and stop
        // goes out anyway. Sound 3 keeps one stale user.
        send_request(6'd1, 5'd3, 1'b1);
        send_request(6'd1, 5'd4, 1'b0);
        // One warning plays and stops sound 3: its stale user keeps the count above zero, so no stop goes out.
        send_request(6'd2, 5'd3, 1'b1);
        send_request(6'd2, 5'd3, 1'b0);
        send_request(6'd42, 5'd21, 1'b1);
        send_request(6'd21, 5'd10, 1'b1);
        send_request(6'd42, 5'd21, 1'b0);
        send_request(6'd21, 5'd10, 1'b0);
        send_request(6'd9, 5'd9, 1'b1);
        send_request(6'd10, 5'd9, 1'b1);

        // Under suppression a play request of a running warning stops it,
        // and a play request of a stopped warning does nothing.
        write_suppress(1'b1);
        send_request(6'd9, 5'd9, 1'b1);
        send_request(6'd10, 5'd9, 1'b1);
        send_request(6'd7, 5'd7, 1'b1);
        send_request(6'd7, 5'd7, 1'b0);

        for (int phase = 0; phase < PHASES; phase++) begin
            write_suppress((phase % 3) == 1);
            // The last phase runs at full rate on both sides.
            if (phase == PHASES - 1) idle_on = 1'b0;
            if (phase == 0)
                pump_sound(WARN_IDX_W'($urandom_range(0, WARNINGS - 1)), 5'd17,
                           SOUND_ID_W'($urandom_range(18, SOUNDS - 1)), 70);
            repeat (PHASE_ITEMS) random_request();
        end

        drain();
        repeat (10) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("shared_alert_sound_refcount_top_test OK");
        end else begin
            $display("shared_alert_sound_refcount_top_test NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/sarc_pkg.sv
src/sarc_store.sv
src/shared_alert_sound_refcount_top.sv
sim/sound_command_tracker_pkg.sv
sim/shared_alert_sound_refcount_top_test.sv
